// File: rtl/core/avg_pool_pkg.sv
// shared types, sizes and codes of the average pooling block
package avg_pool_pkg;

   localparam int MAX_WIDTH           = 128;
   localparam int MAX_HEIGHT          = 128;
   localparam int MAX_KERNEL          = 16;
   localparam int DIVIDE_BY_FULL_POOL = 1;

   localparam int PIX_W   = 16;
   localparam int COORD_W = 7;
   localparam int KER_W   = 5;
   localparam int PAD_W   = 4;
   localparam int IMG_W   = 8;

   // signed window coordinates: col times stride plus kernel, with sign and carry
   localparam int CRD_W     = 14;
   localparam int ADDR_W    = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int XW        = $clog2(MAX_WIDTH + 1);
   localparam int YW        = $clog2(MAX_HEIGHT + 1);
   localparam int KDIM_W    = $clog2(MAX_KERNEL + 1);
   localparam int DIV_W     = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
   localparam int SUM_W     = PIX_W + $clog2(MAX_KERNEL * MAX_KERNEL);
   localparam int DIV_CNT_W = $clog2(SUM_W);

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = IMG_W;

   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_HEIGHT = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_X      = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_Y      = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_X         = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_Y         = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 4'd7;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic                     kind;
      logic [COORD_W-1:0]       col;
      logic [COORD_W-1:0]       row;
      logic signed [PIX_W-1:0]  pixel;
   } req_word_type;

   typedef struct packed {
      logic signed [PIX_W-1:0]  average;
      logic                     error;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BOUND,
      ST_START,
      ST_SCAN,
      ST_DRAIN,
      ST_DIV_INIT,
      ST_DIV,
      ST_FINISH
   } state_type;

endpackage

// File: rtl/core/average_pool_2d_window_top.sv
// 2d average pooling over one image plane held in a frame store
//
// req channel (valid/ready) carries load and query words. a load writes its
// pixel into the frame store in the cycle it is accepted and gives no result;
// loads outside the image are dropped. a query names an output position and
// gives one rsp word: the window mean, truncated toward zero, or the error flag.
// a query's rsp word is built in order: bound setup (ST_BOUND, ST_START), one
// frame store read per window pixel on the single read port, a drain state, a
// divider load state, a 24-step restoring divider, one bit a cycle, and the
// output state; a query that ends in an error goes from bound setup straight to
// the output state. a load leaves the control idle. one word is worked on at a
// time; req_ready is high while the block is idle, also while a finished result
// still sits in the output register. when the receiver stalls, a finished query
// waits until the output register is free. reset puts the control idle, clears
// the output valid and sets the configuration registers to their defaults; the
// frame store is not cleared, and a pixel must be loaded before a query reads it.
// configuration is written through csr_we/csr_index/csr_wdata; the user must
// write it only while idle, the block itself does not enforce this.
module average_pool_2d_window_top
   import avg_pool_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_word,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [KER_W-1:0] kw_ff, kh_ff, sx_ff, sy_ff;
   logic [PAD_W-1:0] px_ff, py_ff;
   logic [IMG_W-1:0] img_w_ff, img_h_ff;

   logic signed [PIX_W-1:0] mem [MAX_WIDTH*MAX_HEIGHT];
   logic signed [PIX_W-1:0] rd_data_ff;
   logic                    rd_vld_ff;

   logic signed [CRD_W-1:0] ws_ff, hs_ff, ws_in, hs_in;
   logic signed [CRD_W-1:0] w_eff, h_eff, col_s, row_s;
   logic signed [CRD_W-1:0] kw_s, kh_s, sx_s, sy_s, px_s, py_s;
   logic signed [CRD_W-1:0] we_cap, he_cap, ws_c, hs_c, we_c, he_c;
   logic signed [CRD_W-1:0] dw_full, dh_full;
   logic                    win_err, ker_err, load_ok;

   logic [XW-1:0]     x0_ff, x1_ff, xcnt_ff;
   logic [YW-1:0]     y0_ff, y1_ff, ycnt_ff;
   logic [KDIM_W-1:0] dw_ff, dh_ff;
   logic              err_ff;
   logic [ADDR_W-1:0] row_base_ff, addr_ff, wr_addr;
   logic [DIV_W-1:0]  divisor_ff, rem_ff, rem_in;
   logic [DIV_W:0]    rem_sh;
   logic              quo_bit;

   logic signed [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0]        quo_ff, quo_neg;
   logic                    neg_ff;
   logic [DIV_CNT_W-1:0]    div_cnt_ff;

   logic req_accept, query_accept, mem_we, scan_issue, last_x, last_y, div_done, out_load;
   logic rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kw_ff    <= KER_W'(2);
         kh_ff    <= KER_W'(2);
         sx_ff    <= KER_W'(2);
         sy_ff    <= KER_W'(2);
         px_ff    <= '0;
         py_ff    <= '0;
         img_w_ff <= IMG_W'(128);
         img_h_ff <= IMG_W'(128);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KERNEL_WIDTH:  kw_ff    <= csr_wdata[KER_W-1:0];
            CSR_KERNEL_HEIGHT: kh_ff    <= csr_wdata[KER_W-1:0];
            CSR_STRIDE_X:      sx_ff    <= csr_wdata[KER_W-1:0];
            CSR_STRIDE_Y:      sy_ff    <= csr_wdata[KER_W-1:0];
            CSR_PAD_X:         px_ff    <= csr_wdata[PAD_W-1:0];
            CSR_PAD_Y:         py_ff    <= csr_wdata[PAD_W-1:0];
            CSR_IMAGE_WIDTH:   img_w_ff <= csr_wdata;
            CSR_IMAGE_HEIGHT:  img_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective image size and signed operands
   always_comb begin
      if (int'(img_w_ff) > MAX_WIDTH) w_eff = CRD_W'(MAX_WIDTH);
      else                            w_eff = CRD_W'(img_w_ff);
      if (int'(img_h_ff) > MAX_HEIGHT) h_eff = CRD_W'(MAX_HEIGHT);
      else                             h_eff = CRD_W'(img_h_ff);
      col_s = CRD_W'(req_word.col);
      row_s = CRD_W'(req_word.row);
      kw_s  = CRD_W'(kw_ff);
      kh_s  = CRD_W'(kh_ff);
      sx_s  = CRD_W'(sx_ff);
      sy_s  = CRD_W'(sy_ff);
      px_s  = CRD_W'(px_ff);
      py_s  = CRD_W'(py_ff);
   end

   assign load_ok = (col_s < w_eff) && (row_s < h_eff);
   assign wr_addr = ADDR_W'(int'(req_word.row) * MAX_WIDTH + int'(req_word.col));
   assign ws_in   = col_s * sx_s - px_s;
   assign hs_in   = row_s * sy_s - py_s;
   assign ker_err = (int'(kw_ff) < 1) || (int'(kh_ff) < 1) ||
                    (int'(kw_ff) > MAX_KERNEL) || (int'(kh_ff) > MAX_KERNEL) ||
                    ((kw_ff >> 1) < KER_W'(px_ff)) || ((kh_ff >> 1) < KER_W'(py_ff));

   // window bounds: cap at image plus padding, then clip to the image
   always_comb begin
      we_cap = (ws_ff + kw_s < w_eff + px_s) ? ws_ff + kw_s : w_eff + px_s;
      he_cap = (hs_ff + kh_s < h_eff + py_s) ? hs_ff + kh_s : h_eff + py_s;
      ws_c   = (ws_ff < 0) ? '0 : ws_ff;
      hs_c   = (hs_ff < 0) ? '0 : hs_ff;
      we_c   = (we_cap > w_eff) ? w_eff : we_cap;
      he_c   = (he_cap > h_eff) ? h_eff : he_cap;
      win_err = (we_c <= ws_c) || (he_c <= hs_c);
      if (DIVIDE_BY_FULL_POOL != 0) begin
         dw_full = we_cap - ws_ff;
         dh_full = he_cap - hs_ff;
      end else begin
         dw_full = we_c - ws_c;
         dh_full = he_c - hs_c;
      end
   end

   assign last_x = (XW'(xcnt_ff + 1'b1) == x1_ff);
   assign last_y = (YW'(ycnt_ff + 1'b1) == y1_ff);
   assign div_done = (div_cnt_ff == DIV_CNT_W'(SUM_W - 1));

   // one restoring step of the magnitude divide
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[SUM_W-1]};
      quo_bit = (rem_sh >= {1'b0, divisor_ff});
      if (quo_bit) rem_in = DIV_W'(rem_sh - {1'b0, divisor_ff});
      else         rem_in = rem_sh[DIV_W-1:0];
      quo_neg = SUM_W'(~quo_ff + 1'b1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (query_accept) state_in = ST_BOUND;
         ST_BOUND:    state_in = ST_START;
         ST_START:    state_in = (err_ff || win_err) ? ST_FINISH : ST_SCAN;
         ST_SCAN:     if (last_x && last_y) state_in = ST_DRAIN;
         ST_DRAIN:    state_in = ST_DIV_INIT;
         ST_DIV_INIT: state_in = ST_DIV;
         ST_DIV:      if (div_done) state_in = ST_FINISH;
         ST_FINISH:   if (out_load) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready  = 1'b0;
      scan_issue = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready  = 1'b1;
         ST_SCAN:   scan_issue = 1'b1;
         ST_FINISH: out_load   = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign req_accept   = req_valid && req_ready;
   assign query_accept = req_accept && (req_word.kind == KIND_QUERY);
   assign mem_we       = req_accept && (req_word.kind == KIND_LOAD) && load_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= scan_issue;
         if (out_load)       rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // frame store
   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= req_word.pixel;
      if (scan_issue) rd_data_ff <= mem[addr_ff];
   end

   // query datapath
   always_ff @(posedge clock) begin
      if (query_accept) begin
         ws_ff  <= ws_in;
         hs_ff  <= hs_in;
         err_ff <= ker_err;
      end
      if (state_ff == ST_BOUND) begin
         x0_ff <= ws_c[XW-1:0];
         x1_ff <= we_c[XW-1:0];
         y0_ff <= hs_c[YW-1:0];
         y1_ff <= he_c[YW-1:0];
         dw_ff <= dw_full[KDIM_W-1:0];
         dh_ff <= dh_full[KDIM_W-1:0];
         err_ff <= err_ff || win_err;
      end
      if (state_ff == ST_START) begin
         divisor_ff  <= DIV_W'(dw_ff * dh_ff);
         row_base_ff <= ADDR_W'(int'(y0_ff) * MAX_WIDTH + int'(x0_ff));
         addr_ff     <= ADDR_W'(int'(y0_ff) * MAX_WIDTH + int'(x0_ff));
         xcnt_ff     <= x0_ff;
         ycnt_ff     <= y0_ff;
         quo_ff      <= '0;
         neg_ff      <= 1'b0;
      end
      if (scan_issue) begin
         // walk the window row by row through the store
         if (last_x) begin
            xcnt_ff     <= x0_ff;
            ycnt_ff     <= YW'(ycnt_ff + 1'b1);
            row_base_ff <= ADDR_W'(int'(row_base_ff) + MAX_WIDTH);
            addr_ff     <= ADDR_W'(int'(row_base_ff) + MAX_WIDTH);
         end else begin
            xcnt_ff <= XW'(xcnt_ff + 1'b1);
            addr_ff <= ADDR_W'(addr_ff + 1'b1);
         end
      end
      priority if (state_ff == ST_START) begin
         sum_ff <= '0;
      end else if (rd_vld_ff) begin
         sum_ff <= sum_ff + SUM_W'(rd_data_ff);
      end
      if (state_ff == ST_DIV_INIT) begin
         neg_ff     <= sum_ff[SUM_W-1];
         quo_ff     <= sum_ff[SUM_W-1] ? SUM_W'(~sum_ff + 1'b1) : SUM_W'(sum_ff);
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end
      if (state_ff == ST_DIV) begin
         rem_ff     <= rem_in;
         quo_ff     <= {quo_ff[SUM_W-2:0], quo_bit};
         div_cnt_ff <= DIV_CNT_W'(div_cnt_ff + 1'b1);
      end
      if (out_load) begin
         rsp_word_ff.average <= neg_ff ? quo_neg[PIX_W-1:0] : quo_ff[PIX_W-1:0];
         rsp_word_ff.error   <= err_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// File: rtl/core/avg_pool_checker.sv
// port level checks of the average pooling block, bound to the top level
module avg_pool_checker
   import avg_pool_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input req_word_type          req_word,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_word_type          rsp_word
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // an accepted query makes the block busy
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_word.kind == KIND_QUERY) |=> !req_ready)
      else $error("block ready right after a query");

   // a load finishes in its own cycle
   a_load_done: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_word.kind == KIND_LOAD) |=> req_ready)
      else $error("block busy after a load");

   // a new result only comes out of a busy block
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) |-> !$past(req_ready))
      else $error("result word appeared while idle");

   // error results carry a zero average
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.error |-> rsp_word.average == '0)
      else $error("error result with nonzero average");

endmodule

bind average_pool_2d_window_top avg_pool_checker u_avg_pool_checker (.*);
